/* sv/bdq_pkg.sv */
// package for the bounded double-ended queue
// holds command, status and cell control types shared by bdq_cell and the top level
package bdq_pkg;

    localparam int DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // register map
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_PUSH_REAR,
        OP_POP_REAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

endpackage

/* sv/bdq_cell.sv */
// one storage cell of the deque chain: element, occupied flag and return lane stage
// depends on bdq_pkg
module bdq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdq_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [bdq_pkg::DATA_W-1:0]  i_prev_data,
    input  logic                               i_prev_valid,
    input  logic signed [bdq_pkg::DATA_W-1:0]  i_next_data,
    input  logic                               i_next_valid,
    input  logic signed [bdq_pkg::DATA_W-1:0]  i_next_ret,
    output logic signed [bdq_pkg::DATA_W-1:0]  o_data,
    output logic                               o_valid,
    output logic signed [bdq_pkg::DATA_W-1:0]  o_ret
);
    import bdq_pkg::*;

    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_valid, n_valid;
    logic signed [DATA_W-1:0] r_ret, n_ret;
    logic                     w_first_empty;
    logic                     w_tail;

    assign w_first_empty = i_prev_valid && !r_valid;
    assign w_tail        = r_valid && !i_next_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        // return lane moves one cell toward the front every cycle
        n_ret   = i_next_ret;
        unique case (i_ctrl.op)
            OP_NONE: begin
            end
            OP_PUSH_FRONT: begin
                n_data  = i_prev_data;
                n_valid = i_prev_valid;
            end
            OP_POP_FRONT: begin
                n_data  = i_next_data;
                n_valid = i_next_valid;
            end
            OP_PUSH_REAR: begin
                if (w_first_empty) begin
                    n_data  = i_ctrl.value;
                    n_valid = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (w_tail) begin
                    n_valid = 1'b0;
                    n_ret   = r_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_ret  <= n_ret;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_ret   = r_ret;

endmodule

/* sv/bounded_double_ended_queue.sv */
// top level of the bounded double-ended queue: command decode, apb register, cell chain
// depends on bdq_pkg and bdq_cell
//
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------
//  command   | start / busy     | i_command, i_push_value
//  result    | o_valid          | o_pop_value, o_status, o_occupancy
//  config    | psel/penable/... | paddr, pwdata, prdata
//
// push front, push rear, pop front and every failed command: the result
// appears the cycle after start is taken. pop rear: the rear element travels
// one cell per cycle along the return lane to cell 0 while busy stays high; the
// result follows right after it arrives there. reset clears the element count
// and occupied flags and sets capacity (16); the receiver cannot stall, each
// result is shown for one cycle only.
module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_command,
    input  logic signed [bdq_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_valid,
    output logic signed [bdq_pkg::DATA_W-1:0]  o_pop_value,
    output logic [1:0]                         o_status,
    output logic [4:0]                         o_occupancy,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int OW = (CW > 5) ? CW : 5;
    localparam logic [OW-1:0] DEPTH_EXT = OW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_REAR = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_wait, n_wait;
    logic [4:0]               r_capacity;
    logic                     r_valid_o, n_valid_o;
    logic signed [DATA_W-1:0] r_pop, n_pop;
    logic [1:0]               r_status, n_status;
    logic [4:0]               r_occ, n_occ;

    t_cell_ctrl               w_ctrl;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic [OW-1:0]            w_cap_ext;
    logic [OW-1:0]            w_eff_cap;
    logic [OW-1:0]            w_occ_ext;

    logic signed [DATA_W-1:0] w_data  [DEPTH];
    logic signed [DATA_W-1:0] w_ret   [DEPTH];
    logic [DEPTH-1:0]         w_valid;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {27'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
            r_capacity <= pwdata[4:0];
        end
    end

    assign busy     = (r_state == S_REAR);
    assign w_accept = start && !busy;

    assign w_cap_ext = OW'(r_capacity);
    assign w_eff_cap = (w_cap_ext > DEPTH_EXT) ? DEPTH_EXT : w_cap_ext;
    assign w_full    = OW'(r_count) >= w_eff_cap;
    assign w_empty   = (r_count == '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_wait    = r_wait;
        n_valid_o = 1'b0;
        n_pop     = '0;
        n_status  = ST_OK;
        w_ctrl.op    = OP_NONE;
        w_ctrl.value = i_push_value;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                            n_valid_o = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctrl.op = (i_command == CMD_PUSH_FRONT) ?
                                            OP_PUSH_FRONT : OP_PUSH_REAR;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            n_valid_o = 1'b1;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctrl.op = OP_POP_FRONT;
                                n_pop     = w_data[0];
                                n_count   = r_count - 1'b1;
                            end
                        end
                        CMD_POP_REAR: begin
                            if (w_empty) begin
                                n_valid_o = 1'b1;
                                n_status  = ST_EMPTY;
                            end else begin
                                // tail drops into the return lane, reaches cell 0 later
                                w_ctrl.op = OP_POP_REAR;
                                n_count   = r_count - 1'b1;
                                n_wait    = IW'(r_count - 1'b1);
                                n_state   = S_REAR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REAR: begin
                if (r_wait == '0) begin
                    n_valid_o = 1'b1;
                    n_pop     = w_ret[0];
                    n_state   = S_IDLE;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_occ_ext = OW'(n_count);
        n_occ     = w_occ_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid_o <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid_o <= n_valid_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wait   <= n_wait;
        r_pop    <= n_pop;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    assign o_valid     = r_valid_o;
    assign o_pop_value = r_pop;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    // cell chain, cell 0 holds the front element
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev_data;
        logic                     w_prev_valid;
        logic signed [DATA_W-1:0] w_next_data;
        logic                     w_next_valid;
        logic signed [DATA_W-1:0] w_next_ret;

        if (g == 0) begin : g_first
            assign w_prev_data  = i_push_value;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
            assign w_next_ret   = '0;
        end else begin : g_inner
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
            assign w_next_ret   = w_ret[g+1];
        end

        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .i_next_ret   (w_next_ret),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_ret        (w_ret[g])
        );
    end

`ifndef SYNTH
    // occupied cells always match the element count
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("occupied cells differ from element count");

    // occupied cells stay packed against the front
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("gap in occupied cells");

    // no result is shown while a rear pop is still in flight
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && busy))
        else $error("result strobe while busy");

    // a taken push or front pop gives its result in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command != CMD_POP_REAR) |=> o_valid)
        else $error("missing result after one-cycle command");
`endif

endmodule
